### design/krs_pkg.sv
// Package for the keyed record store: table size, derived widths, operation codes
// and the command and status structs between the controller and the datapath.
// It depends on nothing else.
`default_nettype none

package krs_pkg;

  // Number of records the table holds.
  localparam int TABLE_DEPTH = 16;

  // Width of a slot index and of a count that can hold TABLE_DEPTH itself.
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  // Field widths of the request and response transactions.
  localparam int OP_W    = 2;
  localparam int KEY_W   = 32;
  localparam int DATA_W  = 64;
  localparam int SLOTS_W = 5;

  // Index of the last slot that the scan visits.
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  // Operation codes carried by a request.
  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 2'd0,
    OP_GET    = 2'd1,
    OP_REMOVE = 2'd2
  } op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             load;
    logic             scan;
    logic [IDX_W-1:0] scan_idx;
    logic             commit;
  } krs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } krs_stat_t;

endpackage

`default_nettype wire

### design/krs_req_if.sv
// Request channel of the keyed record store: handshake plus operation, key and data.
// It depends on krs_pkg for the field widths.
`default_nettype none

interface krs_req_if;
  logic                       valid;
  logic                       ready;
  logic [krs_pkg::OP_W-1:0]   operation;
  logic [krs_pkg::KEY_W-1:0]  record_key;
  logic [krs_pkg::DATA_W-1:0] record_data;

  modport source (output valid, output operation, output record_key, output record_data,
                  input ready);
  modport sink (input valid, input operation, input record_key, input record_data,
                output ready);
endinterface

`default_nettype wire

### design/krs_rsp_if.sv
// Response channel of the keyed record store: handshake plus flags, data and counts.
// It depends on krs_pkg for the field widths.
`default_nettype none

interface krs_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        hit;
  logic                        stored;
  logic [krs_pkg::DATA_W-1:0]  read_data;
  logic [krs_pkg::SLOTS_W-1:0] used_slots;
  logic [krs_pkg::SLOTS_W-1:0] free_slots;

  modport source (output valid, output hit, output stored, output read_data,
                  output used_slots, output free_slots, input ready);
  modport sink (input valid, input hit, input stored, input read_data,
                input used_slots, input free_slots, output ready);
endinterface

`default_nettype wire

### design/krs_ram.sv
// Generic simple dual-port RAM: one write port and one read port with registered data.
// It depends on nothing else.
`default_nettype none

module krs_ram #(
  parameter int  WIDTH  = 32,
  parameter int  DEPTH  = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### design/krs_ctrl.sv
// Controller of the keyed record store: the request state machine and the scan counter.
// It depends on krs_pkg for the command and status structs.
`default_nettype none

module krs_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  output logic                    req_ready,
  input  wire krs_pkg::krs_stat_t stat,
  output krs_pkg::krs_cmd_t       cmd
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_UPDATE = 4'b1000
  } state_t;

  state_t                    state;
  state_t                    state_next;
  logic [krs_pkg::IDX_W-1:0] scan_idx;
  logic [krs_pkg::IDX_W-1:0] scan_idx_next;

  // Next state and scan address.
  always_comb begin
    state_next    = state;
    scan_idx_next = scan_idx;
    case (state)
      ST_IDLE: begin
        scan_idx_next = '0;
        if (req_valid) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_idx == krs_pkg::LAST_IDX) begin
          state_next = ST_DRAIN;
        end else begin
          scan_idx_next = scan_idx + krs_pkg::IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      scan_idx <= '0;
    end else begin
      state    <= state_next;
      scan_idx <= scan_idx_next;
    end
  end

  // Commands to the datapath.
  always_comb begin
    req_ready    = (state == ST_IDLE);
    cmd.load     = req_valid && (state == ST_IDLE);
    cmd.scan     = (state == ST_SCAN);
    cmd.scan_idx = scan_idx;
    cmd.commit   = (state == ST_UPDATE) && stat.out_free;
  end

  // An accepted transaction starts the scan at slot zero.
  a_scan_start: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == ST_SCAN) && (scan_idx == '0))
    else $error("scan did not start at slot zero after a request");

  // The drain cycle follows only the read of the last slot.
  a_drain_after_last: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAIN) |-> $past(state == ST_SCAN && scan_idx == krs_pkg::LAST_IDX))
    else $error("drain reached before the whole table was read");

  // A committed result frees the controller for the next request.
  a_commit_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> (state == ST_IDLE) && req_ready)
    else $error("controller not idle after commit");

endmodule

`default_nettype wire

### design/krs_dpath.sv
// Datapath of the keyed record store: key and data RAMs, valid bits, slot count,
// scan compare and the response register. It depends on krs_pkg and krs_ram.
`default_nettype none

module krs_dpath (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire krs_pkg::krs_cmd_t           cmd,
  output krs_pkg::krs_stat_t               stat,
  input  wire logic [krs_pkg::OP_W-1:0]    req_operation,
  input  wire logic [krs_pkg::KEY_W-1:0]   req_key,
  input  wire logic [krs_pkg::DATA_W-1:0]  req_data,
  output logic                             rsp_valid,
  input  wire logic                        rsp_ready,
  output logic                             rsp_hit,
  output logic                             rsp_stored,
  output logic [krs_pkg::DATA_W-1:0]       rsp_read_data,
  output logic [krs_pkg::SLOTS_W-1:0]      rsp_used_slots,
  output logic [krs_pkg::SLOTS_W-1:0]      rsp_free_slots
);

  // Latched request.
  logic [krs_pkg::OP_W-1:0]   op;
  logic [krs_pkg::KEY_W-1:0]  key;
  logic [krs_pkg::DATA_W-1:0] data;

  // Table state held in flip-flops.
  logic [krs_pkg::TABLE_DEPTH-1:0] valid;
  logic [krs_pkg::CNT_W-1:0]       count;

  // Compare stage, registered from the RAM read address so that it lines up with the RAM data.
  logic                       cmp_en;
  logic [krs_pkg::IDX_W-1:0]  cmp_idx;
  logic [krs_pkg::KEY_W-1:0]  key_rd;
  logic [krs_pkg::DATA_W-1:0] data_rd;

  // Scan results.
  logic                       found;
  logic [krs_pkg::IDX_W-1:0]  match_idx;
  logic [krs_pkg::DATA_W-1:0] match_data;
  logic                       free_found;
  logic [krs_pkg::IDX_W-1:0]  free_idx;

  // Update decision.
  logic                       key_we;
  logic                       data_we;
  logic [krs_pkg::IDX_W-1:0]  waddr;
  logic [krs_pkg::CNT_W-1:0]  count_next;
  logic                       set_valid;
  logic                       clr_valid;
  logic                       hit_next;
  logic                       stored_next;
  logic [krs_pkg::DATA_W-1:0] read_data_next;

  krs_ram #(
    .WIDTH (krs_pkg::KEY_W),
    .DEPTH (krs_pkg::TABLE_DEPTH)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (waddr),
    .wdata (key),
    .raddr (cmd.scan_idx),
    .rdata (key_rd)
  );

  krs_ram #(
    .WIDTH (krs_pkg::DATA_W),
    .DEPTH (krs_pkg::TABLE_DEPTH)
  ) u_data_ram (
    .clk   (clk),
    .we    (data_we),
    .waddr (waddr),
    .wdata (data),
    .raddr (cmd.scan_idx),
    .rdata (data_rd)
  );

  // Request register, loaded when a transaction is accepted.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op   <= req_operation;
      key  <= req_key;
      data <= req_data;
    end
  end

  // Compare stage: track the address whose RAM data arrives next cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_en <= 1'b0;
    end else begin
      cmp_en <= cmd.scan;
    end
    cmp_idx <= cmd.scan_idx;
  end

  // First matching valid entry and first free slot found during the scan.
  always_ff @(posedge clk) begin
    if (rst) begin
      found      <= 1'b0;
      free_found <= 1'b0;
    end else if (cmd.load) begin
      found      <= 1'b0;
      free_found <= 1'b0;
    end else if (cmp_en) begin
      if (!found && valid[cmp_idx] && (key_rd == key)) begin
        found <= 1'b1;
      end
      if (!free_found && !valid[cmp_idx]) begin
        free_found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmp_en && !found && valid[cmp_idx] && (key_rd == key)) begin
      match_idx  <= cmp_idx;
      match_data <= data_rd;
    end
    if (cmp_en && !free_found && !valid[cmp_idx]) begin
      free_idx <= cmp_idx;
    end
  end

  // Outcome of the request once the scan is complete.
  always_comb begin
    key_we         = 1'b0;
    data_we        = 1'b0;
    waddr          = match_idx;
    count_next     = count;
    set_valid      = 1'b0;
    clr_valid      = 1'b0;
    hit_next       = 1'b0;
    stored_next    = 1'b0;
    read_data_next = '0;
    case (krs_pkg::op_t'(op))
      krs_pkg::OP_ADD: begin
        if (found) begin
          data_we     = cmd.commit;
          hit_next    = 1'b1;
          stored_next = 1'b1;
        end else if (free_found) begin
          waddr       = free_idx;
          key_we      = cmd.commit;
          data_we     = cmd.commit;
          set_valid   = 1'b1;
          count_next  = count + krs_pkg::CNT_W'(1);
          stored_next = 1'b1;
        end
      end
      krs_pkg::OP_GET: begin
        if (found) begin
          hit_next       = 1'b1;
          read_data_next = match_data;
        end
      end
      krs_pkg::OP_REMOVE: begin
        if (found) begin
          clr_valid = 1'b1;
          hit_next  = 1'b1;
          if (count != '0) begin
            count_next = count - krs_pkg::CNT_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Table state update at commit.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      count <= '0;
    end else if (cmd.commit) begin
      count <= count_next;
      if (set_valid) begin
        valid[free_idx] <= 1'b1;
      end
      if (clr_valid) begin
        valid[match_idx] <= 1'b0;
      end
    end
  end

  // Response register: holds a finished transaction until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.commit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rsp_hit        <= hit_next;
      rsp_stored     <= stored_next;
      rsp_read_data  <= read_data_next;
      rsp_used_slots <= krs_pkg::SLOTS_W'(count_next);
      rsp_free_slots <= krs_pkg::SLOTS_W'(krs_pkg::CNT_W'(krs_pkg::TABLE_DEPTH) - count_next);
    end
  end

  assign stat.out_free = !rsp_valid || rsp_ready;

  // The slot count always agrees with the valid bits.
  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    $countones(valid) == count)
    else $error("slot count differs from the number of valid entries");

  // A commit never overwrites a response that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!rsp_valid || rsp_ready))
    else $error("response register overwritten before it was taken");

  // Only an add can report a stored entry.
  a_stored_on_add: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && stored_next) |-> (krs_pkg::op_t'(op) == krs_pkg::OP_ADD))
    else $error("stored flag raised on a request that is not an add");

endmodule

`default_nettype wire

### design/keyed_record_store_unit.sv
// Keyed record store: an accepted request runs through a scan of all TABLE_DEPTH slots
// (one slot read per cycle), a drain state and an update state; the response is registered at commit.
// One request is in work at a time; the next is accepted the cycle after the commit. A
// waiting response holds the next request in its update state. Synchronous reset clears
// the valid bits and slot count at once, with no clearing pass. Uses krs_pkg, krs_req_if,
// krs_rsp_if, krs_ctrl and krs_dpath.
`default_nettype none

module keyed_record_store_unit (
  input  wire logic clk,
  input  wire logic rst,
  krs_req_if.sink   req,
  krs_rsp_if.source rsp
);

  krs_pkg::krs_cmd_t  cmd;
  krs_pkg::krs_stat_t stat;

  krs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  krs_dpath u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .req_operation  (req.operation),
    .req_key        (req.record_key),
    .req_data       (req.record_data),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_hit        (rsp.hit),
    .rsp_stored     (rsp.stored),
    .rsp_read_data  (rsp.read_data),
    .rsp_used_slots (rsp.used_slots),
    .rsp_free_slots (rsp.free_slots)
  );

endmodule

`default_nettype wire
